// File: src/tea_variant_block_encrypt_assert.svh
// Assertion macros for the block cipher pipeline.
`ifndef TEA_VARIANT_BLOCK_ENCRYPT_ASSERT_SVH
`define TEA_VARIANT_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TVBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TVBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tvbe_pkg.sv
package tvbe_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Round constant added to the running sum before each round
  localparam word_t DELTA = 32'h9e3779b9;

  // Register indexes on the configuration port
  localparam int unsigned REG_IDX_W = 2;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_KEY0 = 2'd0;
  localparam reg_idx_t REG_KEY1 = 2'd1;
  localparam reg_idx_t REG_KEY2 = 2'd2;
  localparam reg_idx_t REG_KEY3 = 2'd3;

  // Key reset values
  localparam word_t KEY0_RST = 32'h13371337;
  localparam word_t KEY1_RST = 32'h9e3779b9;
  localparam word_t KEY2_RST = 32'h41414141;
  localparam word_t KEY3_RST = 32'hdeadbeef;

endpackage

// File: src/tvbe_if.sv
// Plaintext channel
interface tvbe_in_if;
  logic            valid;
  logic            ready;
  tvbe_pkg::word_t plain_first;
  tvbe_pkg::word_t plain_second;

  modport source (output valid, output plain_first, output plain_second, input ready);
  modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

// Ciphertext channel
interface tvbe_out_if;
  logic            valid;
  logic            ready;
  tvbe_pkg::word_t cipher_first;
  tvbe_pkg::word_t cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

// File: src/tea_variant_block_encrypt.sv
// TEA-style 64-bit block encryption with a 128-bit key held in four APB
// registers. The datapath is a pipeline with one register stage per
// half-round, 2*ROUND_COUNT stages in all. A block is accepted every
// cycle while the input is ready. Its result shows on the output once it
// reaches the last stage and transfers when the output side is ready. Each
// stage holds its item until the next one is free, so a stall at the output
// fills empty stages first and the input stays ready until every stage is
// occupied. Keys must only be written while the pipeline is empty; the
// stages read the key registers directly.
`include "tea_variant_block_encrypt_assert.svh"

module tea_variant_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  tvbe_in_if.sink                 in_ch,
  tvbe_out_if.source              out_ch,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [3:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  // ---------------------------------------------------------------
  // Key registers
  // ---------------------------------------------------------------
  tvbe_pkg::word_t  key0_r, key1_r, key2_r, key3_r;
  tvbe_pkg::reg_idx_t cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= tvbe_pkg::KEY0_RST;
      key1_r <= tvbe_pkg::KEY1_RST;
      key2_r <= tvbe_pkg::KEY2_RST;
      key3_r <= tvbe_pkg::KEY3_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tvbe_pkg::REG_KEY0: key0_r <= cfg_pwdata;
        tvbe_pkg::REG_KEY1: key1_r <= cfg_pwdata;
        tvbe_pkg::REG_KEY2: key2_r <= cfg_pwdata;
        tvbe_pkg::REG_KEY3: key3_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      tvbe_pkg::REG_KEY0: cfg_prdata = key0_r;
      tvbe_pkg::REG_KEY1: cfg_prdata = key1_r;
      tvbe_pkg::REG_KEY2: cfg_prdata = key2_r;
      tvbe_pkg::REG_KEY3: cfg_prdata = key3_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Half-round pipeline
  // ---------------------------------------------------------------
  tvbe_pkg::word_t first_r    [STAGES];
  tvbe_pkg::word_t second_r   [STAGES];
  tvbe_pkg::word_t first_nxt  [STAGES];
  tvbe_pkg::word_t second_nxt [STAGES];
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] stg_rdy;

  // a stage may load when it is empty or its item moves on
  assign stg_rdy[STAGES-1] = !vld_r[STAGES-1] || out_ch.ready;
  assign in_ch.ready       = stg_rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    // running sum of this round, fixed per stage
    localparam logic [63:0] SUM_WIDE = 64'(s / 2 + 1) * 64'(tvbe_pkg::DELTA);
    localparam tvbe_pkg::word_t SUM = SUM_WIDE[31:0];

    tvbe_pkg::word_t prv_first, prv_second, src, mix_left, mix_mid, mix_right, mix;
    tvbe_pkg::word_t key_lft, key_rgt;

    if (s == 0) begin : g_head
      assign prv_first  = in_ch.plain_first;
      assign prv_second = in_ch.plain_second;
      assign vld_nxt[s] = in_ch.valid;
    end else begin : g_body
      assign prv_first  = first_r[s-1];
      assign prv_second = second_r[s-1];
      assign vld_nxt[s] = vld_r[s-1];
    end

    if (s < STAGES - 1) begin : g_rdy
      assign stg_rdy[s] = !vld_r[s] || stg_rdy[s+1];
    end

    // even stages update the first half, odd stages the second
    if (s % 2 == 0) begin : g_even
      assign src     = prv_second;
      assign key_lft = key0_r;
      assign key_rgt = key1_r;
    end else begin : g_odd
      assign src     = prv_first;
      assign key_lft = key2_r;
      assign key_rgt = key3_r;
    end

    assign mix_left  = (src << 4) + key_lft;
    assign mix_mid   = src + SUM;
    assign mix_right = (src >> 5) + key_rgt;
    assign mix       = (mix_left ^ mix_mid) + mix_right;

    if (s % 2 == 0) begin : g_even_upd
      assign first_nxt[s]  = prv_first + mix;
      assign second_nxt[s] = prv_second;
    end else begin : g_odd_upd
      assign first_nxt[s]  = prv_first;
      assign second_nxt[s] = prv_second + mix;
    end

    // payload
    always_ff @(posedge clk) begin
      if (stg_rdy[s]) begin
        first_r[s]  <= first_nxt[s];
        second_r[s] <= second_nxt[s];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (stg_rdy[s]) begin
          vld_r[s] <= vld_nxt[s];
        end
      end
    end
  end

  assign out_ch.valid         = vld_r[STAGES-1];
  assign out_ch.cipher_first  = first_r[STAGES-1];
  assign out_ch.cipher_second = second_r[STAGES-1];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `TVBE_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_ch.ready, &vld_r,
    "input blocked while a pipeline stage is empty")
  `TVBE_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0],
    "accepted block did not enter the first stage")
  `TVBE_ASSERT_NEXT(a_key_hold, clk, rst_n, !cfg_wr,
    $stable(key0_r) && $stable(key1_r) && $stable(key2_r) && $stable(key3_r),
    "key changed without a register write")

endmodule
